[src/tawc_pkg.sv]
// Shared types and constants for the three-axis average with calibration.
// Holds the request and result structs, the queue entry type and LED codes.
// No dependencies.
package tawc_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int WINDOW_DEPTH = 8;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int SUM_BITS     = SAMPLE_BITS + WIN_AW;
    localparam int STEP_BITS    = 3;
    localparam int AXES         = 3;
    localparam int AXIS_AW      = 2;

    localparam logic [STEP_BITS-1:0] FINAL_STEP = 3'd6;

    // request kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_PRESS  = 1'b1;

    // LED prompt codes per calibration step
    localparam logic [7:0] LED_MAX_X = 8'h08;
    localparam logic [7:0] LED_MIN_X = 8'h02;
    localparam logic [7:0] LED_MAX_Y = 8'h20;
    localparam logic [7:0] LED_MIN_Y = 8'hAA;
    localparam logic [7:0] LED_MAX_Z = 8'h55;
    localparam logic [7:0] LED_MIN_Z = 8'h00;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [STEP_BITS-1:0]   step_t;

    typedef struct packed {
        logic    command;
        sample_t x_sample;
        sample_t y_sample;
        sample_t z_sample;
    } item_t;

    typedef struct packed {
        sample_t     x_average;
        sample_t     y_average;
        sample_t     z_average;
        sample_t     x_offset;
        sample_t     y_offset;
        sample_t     z_offset;
        logic [7:0]  led_status;
        step_t       calibration_step;
        logic        calibration_done;
    } result_t;

    // one queued operation between front and back
    typedef struct packed {
        logic    is_press;
        sample_t x_val;
        sample_t y_val;
        sample_t z_val;
    } op_t;

    function automatic logic [7:0] led_code(input step_t step);
        logic [7:0] code;
        case (step)
            3'd0:    code = LED_MAX_X;
            3'd1:    code = LED_MIN_X;
            3'd2:    code = LED_MAX_Y;
            3'd3:    code = LED_MIN_Y;
            3'd4:    code = LED_MAX_Z;
            3'd5:    code = LED_MIN_Z;
            default: code = LED_MIN_Z;
        endcase
        return code;
    endfunction

endpackage

[src/tawc_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
// Two-entry queue lets the input side and the back end stall independently.
// Depends on tawc_pkg.
module tawc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  tawc_pkg::item_t item,
    output logic            op_valid,
    input  logic            op_ready,
    output tawc_pkg::op_t   op
);

    localparam int QDEPTH = 2;

    tawc_pkg::op_t slot_reg [QDEPTH];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push, pop;
    tawc_pkg::op_t op_in;

    // drop sample fields on a press so the back end never sees stale data
    always_comb
    begin
        op_in.is_press = (item.command == tawc_pkg::CMD_PRESS);
        if (op_in.is_press)
        begin
            op_in.x_val = '0;
            op_in.y_val = '0;
            op_in.z_val = '0;
        end
        else
        begin
            op_in.x_val = item.x_sample;
            op_in.y_val = item.y_sample;
            op_in.z_val = item.z_sample;
        end
    end

    assign item_stall = (count_reg == 2'(QDEPTH));
    assign push       = item_valid && !item_stall;
    assign op_valid   = (count_reg != 2'd0);
    assign pop        = op_valid && op_ready;
    assign op         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[src/tawc_back.sv]
// Back end: runs the moving-average filter and the calibration sequence.
// Holds the window, running sums, calibration state and the result register.
// Depends on tawc_pkg.
module tawc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_ready,
    input  tawc_pkg::op_t       op,
    output logic                result_valid,
    input  logic                result_stall,
    output tawc_pkg::result_t   result
);

    localparam int WD = tawc_pkg::WINDOW_DEPTH;
    localparam int AW = tawc_pkg::WIN_AW;
    localparam int SB = tawc_pkg::SAMPLE_BITS;
    localparam int NA = tawc_pkg::AXES;

    tawc_pkg::sample_t x_win_reg [WD];
    tawc_pkg::sample_t y_win_reg [WD];
    tawc_pkg::sample_t z_win_reg [WD];
    tawc_pkg::sum_t    sum_reg   [NA];
    tawc_pkg::sum_t    sum_next  [NA];
    logic [AW-1:0]     pos_reg, pos_next;

    tawc_pkg::sample_t max_reg [NA];
    tawc_pkg::sample_t min_reg [NA];
    tawc_pkg::sample_t off_reg [NA];
    tawc_pkg::sample_t max_next [NA];
    tawc_pkg::sample_t min_next [NA];
    tawc_pkg::sample_t off_next [NA];
    tawc_pkg::sample_t avg [NA];
    tawc_pkg::step_t   step_reg, step_next;
    logic [7:0]        led_reg, led_next;

    logic                 result_valid_reg;
    tawc_pkg::result_t    result_reg, result_next;
    logic                 fire;
    logic                 do_sample;
    logic                 do_cal;
    logic [tawc_pkg::AXIS_AW-1:0] axis;
    logic [SB:0]          mid_sum;

    assign op_ready     = !result_valid_reg || !result_stall;
    assign fire         = op_valid && op_ready;
    assign do_sample    = fire && !op.is_press;
    assign do_cal       = fire && op.is_press && (step_reg < tawc_pkg::FINAL_STEP);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            avg[a] = sum_reg[a][tawc_pkg::SUM_BITS-1:AW];
        end
        axis = step_reg[tawc_pkg::STEP_BITS-1:1];

        // sum += new - replaced; stays within range since the window is exact
        sum_next[0] = sum_reg[0] + tawc_pkg::sum_t'(op.x_val) - tawc_pkg::sum_t'(x_win_reg[pos_reg]);
        sum_next[1] = sum_reg[1] + tawc_pkg::sum_t'(op.y_val) - tawc_pkg::sum_t'(y_win_reg[pos_reg]);
        sum_next[2] = sum_reg[2] + tawc_pkg::sum_t'(op.z_val) - tawc_pkg::sum_t'(z_win_reg[pos_reg]);
        if (!do_sample)
        begin
            for (int a = 0; a < NA; a++)
            begin
                sum_next[a] = sum_reg[a];
            end
        end
        if (do_sample)
        begin
            pos_next = (pos_reg == AW'(WD - 1)) ? '0 : pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end

        for (int a = 0; a < NA; a++)
        begin
            max_next[a] = max_reg[a];
            min_next[a] = min_reg[a];
            off_next[a] = off_reg[a];
        end
        step_next = step_reg;
        led_next  = led_reg;
        mid_sum   = {1'b0, max_reg[axis]} + {1'b0, avg[axis]};
        if (do_cal)
        begin
            if (step_reg[0] == 1'b0)
            begin
                max_next[axis] = avg[axis];
            end
            else
            begin
                min_next[axis] = avg[axis];
                off_next[axis] = mid_sum[SB:1];
            end
            led_next  = tawc_pkg::led_code(step_reg);
            step_next = step_reg + 1'b1;
        end

        result_next.x_average        = sum_next[0][tawc_pkg::SUM_BITS-1:AW];
        result_next.y_average        = sum_next[1][tawc_pkg::SUM_BITS-1:AW];
        result_next.z_average        = sum_next[2][tawc_pkg::SUM_BITS-1:AW];
        result_next.x_offset         = off_next[0];
        result_next.y_offset         = off_next[1];
        result_next.z_offset         = off_next[2];
        result_next.led_status       = led_next;
        result_next.calibration_step = step_next;
        result_next.calibration_done = (step_next >= tawc_pkg::FINAL_STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WD; i++)
            begin
                x_win_reg[i] <= '0;
                y_win_reg[i] <= '0;
                z_win_reg[i] <= '0;
            end
            for (int a = 0; a < NA; a++)
            begin
                sum_reg[a] <= '0;
                max_reg[a] <= '0;
                min_reg[a] <= '0;
                off_reg[a] <= '0;
            end
            pos_reg          <= '0;
            step_reg         <= '0;
            led_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_sample)
            begin
                x_win_reg[pos_reg] <= op.x_val;
                y_win_reg[pos_reg] <= op.y_val;
                z_win_reg[pos_reg] <= op.z_val;
            end
            for (int a = 0; a < NA; a++)
            begin
                sum_reg[a] <= sum_next[a];
                max_reg[a] <= max_next[a];
                min_reg[a] <= min_next[a];
                off_reg[a] <= off_next[a];
            end
            pos_reg  <= pos_next;
            step_reg <= step_next;
            led_reg  <= led_next;
            if (fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result while stalled, load on every executed request
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[src/three_axis_average_with_calibration.sv]
// Three-axis eight-sample moving average with six-step calibration.
// The request passes through the queue and then the result register; a result stall holds it.
// Throughput: one request per cycle unless the result side stalls; the running-sum update
// and a calibration step are each combinational. A two-entry queue decouples the input stall.
// Reset clears windows, sums, calibration state and the queue; no clearing pass.
module three_axis_average_with_calibration (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  tawc_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_stall,
    output tawc_pkg::result_t   result
);

    logic          op_valid;
    logic          op_ready;
    tawc_pkg::op_t op;

    tawc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op)
    );

    tawc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[verif/tb_three_axis_average_with_calibration.sv]
`timescale 1ns / 100ps
// Self-checking testbench for three_axis_average_with_calibration.
// Predicts the moving averages and the calibration state for every accepted request,
// compares each result field by field. Depends on tawc_pkg and the block's RTL.
module tb_three_axis_average_with_calibration;

    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 10;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    tawc_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    tawc_pkg::result_t result;

    three_axis_average_with_calibration u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // predicted block state
    tawc_pkg::sample_t           win [tawc_pkg::AXES][tawc_pkg::WINDOW_DEPTH];
    tawc_pkg::sum_t              run_sum [tawc_pkg::AXES];
    logic [tawc_pkg::WIN_AW-1:0] win_pos;
    tawc_pkg::sample_t           cap_max [tawc_pkg::AXES];
    tawc_pkg::sample_t           cap_min [tawc_pkg::AXES];
    tawc_pkg::sample_t           zero_point [tawc_pkg::AXES];
    tawc_pkg::step_t             press_count;
    logic [7:0]                  prompt;

    tawc_pkg::result_t expected_status [$];
    tawc_pkg::result_t want_status;
    int                error_count;
    int                burst_left;
    bit                gaps_on;
    int                stall_mode;
    int                stall_left;
    int                stall_tick;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Advance the predicted state by one request and return the status it yields.
    task automatic predict_status(input tawc_pkg::item_t req, output tawc_pkg::result_t res);
        tawc_pkg::sample_t avg [tawc_pkg::AXES];
        tawc_pkg::sample_t val [tawc_pkg::AXES];
        int                axis;
        val[0] = req.x_sample;
        val[1] = req.y_sample;
        val[2] = req.z_sample;
        if (req.command == tawc_pkg::CMD_SAMPLE)
        begin
            for (int a = 0; a < tawc_pkg::AXES; a++)
            begin
                run_sum[a] = run_sum[a] + tawc_pkg::sum_t'(val[a])
                             - tawc_pkg::sum_t'(win[a][win_pos]);
                win[a][win_pos] = val[a];
            end
            win_pos = (win_pos == tawc_pkg::WINDOW_DEPTH - 1) ? '0 : win_pos + 1'b1;
        end
        else if (press_count < tawc_pkg::FINAL_STEP)
        begin
            for (int a = 0; a < tawc_pkg::AXES; a++)
                avg[a] = tawc_pkg::sample_t'(run_sum[a] / tawc_pkg::WINDOW_DEPTH);
            axis = press_count >> 1;
            if (press_count[0] == 1'b0)
                cap_max[axis] = avg[axis];
            else
            begin
                cap_min[axis] = avg[axis];
                zero_point[axis] = tawc_pkg::sample_t'(
                    ({1'b0, cap_max[axis]} + {1'b0, cap_min[axis]}) >> 1);
            end
            case (press_count)
                3'd0:    prompt = tawc_pkg::LED_MAX_X;
                3'd1:    prompt = tawc_pkg::LED_MIN_X;
                3'd2:    prompt = tawc_pkg::LED_MAX_Y;
                3'd3:    prompt = tawc_pkg::LED_MIN_Y;
                3'd4:    prompt = tawc_pkg::LED_MAX_Z;
                default: prompt = tawc_pkg::LED_MIN_Z;
            endcase
            press_count = press_count + 1'b1;
        end
        res.x_average        = tawc_pkg::sample_t'(run_sum[0] / tawc_pkg::WINDOW_DEPTH);
        res.y_average        = tawc_pkg::sample_t'(run_sum[1] / tawc_pkg::WINDOW_DEPTH);
        res.z_average        = tawc_pkg::sample_t'(run_sum[2] / tawc_pkg::WINDOW_DEPTH);
        res.x_offset         = zero_point[0];
        res.y_offset         = zero_point[1];
        res.z_offset         = zero_point[2];
        res.led_status       = prompt;
        res.calibration_step = press_count;
        res.calibration_done = (press_count >= tawc_pkg::FINAL_STEP);
    endtask

    function automatic tawc_pkg::item_t make_request(input logic cmd,
                                                     input tawc_pkg::sample_t x,
                                                     input tawc_pkg::sample_t y,
                                                     input tawc_pkg::sample_t z);
        tawc_pkg::item_t req;
        req.command  = cmd;
        req.x_sample = x;
        req.y_sample = y;
        req.z_sample = z;
        return req;
    endfunction

    // mostly uniform, with the range ends weighted up
    function automatic tawc_pkg::sample_t rand_value();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return tawc_pkg::sample_t'($urandom);
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            item       <= tawc_pkg::item_t'($urandom);
        end
    endtask

    // Drive one request, hold it until accepted, then record its prediction.
    task automatic send_request(input tawc_pkg::item_t req);
        tawc_pkg::result_t res;
        if (gaps_on && burst_left == 0)
        begin
            idle_cycles($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= req;
        do
            @(posedge clk);
        while (item_stall);
        predict_status(req, res);
        expected_status.push_back(res);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
    endtask

    // Averages before the window fills, full-scale window, alternating bit patterns.
    task automatic test_window_extremes();
        send_request(make_request(tawc_pkg::CMD_SAMPLE, '0, '0, '0));
        repeat (tawc_pkg::WINDOW_DEPTH)
            send_request(make_request(tawc_pkg::CMD_SAMPLE, '1, '1, '1));
        send_request(make_request(tawc_pkg::CMD_SAMPLE, 10'h2AA, 10'h155, 10'h2AA));
        send_request(make_request(tawc_pkg::CMD_SAMPLE, 10'h155, 10'h2AA, 10'h155));
        send_request(make_request(tawc_pkg::CMD_SAMPLE, '0, '1, '0));
    endtask

    // Six presses, each preceded by a run of samples steering the axis under calibration.
    task automatic test_calibration_walk();
        tawc_pkg::sample_t target;
        int                axis;
        for (int s = 0; s < tawc_pkg::FINAL_STEP; s++)
        begin
            axis   = s >> 1;
            target = rand_value();
            repeat ($urandom_range(1, 16))
            begin
                if (axis == 0)
                    send_request(make_request(tawc_pkg::CMD_SAMPLE, target,
                                              rand_value(), rand_value()));
                else if (axis == 1)
                    send_request(make_request(tawc_pkg::CMD_SAMPLE, rand_value(),
                                              target, rand_value()));
                else
                    send_request(make_request(tawc_pkg::CMD_SAMPLE, rand_value(),
                                              rand_value(), target));
            end
            // sample fields on a press must be ignored
            send_request(make_request(tawc_pkg::CMD_PRESS, rand_value(), rand_value(),
                                      rand_value()));
        end
    endtask

    // Presses once the sequence is complete change nothing.
    task automatic test_presses_after_done();
        send_request(make_request(tawc_pkg::CMD_PRESS, '0, '0, '0));
        send_request(make_request(tawc_pkg::CMD_PRESS, '1, '1, '1));
        send_request(make_request(tawc_pkg::CMD_SAMPLE, 10'h3FF, 10'h000, 10'h200));
        send_request(make_request(tawc_pkg::CMD_PRESS, 10'h155, 10'h2AA, 10'h155));
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            // a stretch of back-to-back requests
            gaps_on = !(i >= count / 4 && i < count / 4 + 100);
            if (i == count / 2)
                wait_for_drain();
            if ($urandom_range(0, 9) == 0)
                send_request(make_request(tawc_pkg::CMD_PRESS, rand_value(), rand_value(),
                                          rand_value()));
            else
                send_request(make_request(tawc_pkg::CMD_SAMPLE, rand_value(), rand_value(),
                                          rand_value()));
        end
        gaps_on = 1'b1;
    endtask

    // receiver stall pattern: switch between modes every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 9) < 3);
            2:       result_stall <= ($urandom_range(0, 9) < 8);
            default: result_stall <= (stall_tick % 4 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_status.size() == 0)
                report_mismatch("result with nothing expected", 1, 0);
            else
            begin
                want_status = expected_status.pop_front();
                if (result.x_average != want_status.x_average)
                    report_mismatch("x_average", result.x_average, want_status.x_average);
                if (result.y_average != want_status.y_average)
                    report_mismatch("y_average", result.y_average, want_status.y_average);
                if (result.z_average != want_status.z_average)
                    report_mismatch("z_average", result.z_average, want_status.z_average);
                if (result.x_offset != want_status.x_offset)
                    report_mismatch("x_offset", result.x_offset, want_status.x_offset);
                if (result.y_offset != want_status.y_offset)
                    report_mismatch("y_offset", result.y_offset, want_status.y_offset);
                if (result.z_offset != want_status.z_offset)
                    report_mismatch("z_offset", result.z_offset, want_status.z_offset);
                if (result.led_status != want_status.led_status)
                    report_mismatch("led_status", result.led_status, want_status.led_status);
                if (result.calibration_step != want_status.calibration_step)
                    report_mismatch("calibration_step", result.calibration_step,
                                    want_status.calibration_step);
                if (result.calibration_done != want_status.calibration_done)
                    report_mismatch("calibration_done", result.calibration_done,
                                    want_status.calibration_done);
            end
        end
    end

    // end the run if nothing moves on either channel for too long
    initial
    begin
        int idle_count;
        idle_count = 0;
        wait (rst_n === 1'b1);
        while (idle_count < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("tb_three_axis_average_with_calibration NOT OK");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        error_count  = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        stall_mode   = 0;
        stall_left   = 0;
        stall_tick   = 0;
        for (int a = 0; a < tawc_pkg::AXES; a++)
        begin
            for (int d = 0; d < tawc_pkg::WINDOW_DEPTH; d++)
                win[a][d] = '0;
            run_sum[a]    = '0;
            cap_max[a]    = '0;
            cap_min[a]    = '0;
            zero_point[a] = '0;
        end
        win_pos     = '0;
        press_count = '0;
        prompt      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_window_extremes();
        test_calibration_walk();
        test_presses_after_done();
        test_random_traffic(650);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_status.size() != 0)
            report_mismatch("results still expected", expected_status.size(), 0);
        if (error_count == 0)
            $display("tb_three_axis_average_with_calibration OK");
        else
            $display("tb_three_axis_average_with_calibration NOT OK");
        $finish;
    end

endmodule
